// File: sv/ffo_pkg.sv
`timescale 1ns / 1ps

package ffo_pkg;

  localparam int unsigned VALUE_W = 32;

  // One word moving down the cell row, with its match and store marks
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               hit;     // equal to an entry of an earlier cell
    logic               stored;  // taken in by an earlier cell
  } ffo_word_t;

endpackage

// File: sv/ffo_in_if.sv
`timescale 1ns / 1ps

interface ffo_in_if;
  import ffo_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

// File: sv/ffo_out_if.sv
`timescale 1ns / 1ps

interface ffo_out_if;
  import ffo_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_out;
  logic               table_full;

  modport source (output valid, output value_out, output table_full, input ready);
  modport sink   (input valid, input value_out, input table_full, output ready);
endinterface

// File: sv/ffo_cell.sv
`timescale 1ns / 1ps

module ffo_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  ffo_pkg::ffo_word_t up_word,
  output ffo_pkg::ffo_word_t down_word,
  output logic              occupied
);
  import ffo_pkg::*;

  logic [VALUE_W-1:0] entry;
  logic               match;
  logic               take;

  // compare against the held entry; an empty cell takes the first new word
  assign match = occupied && (entry == up_word.value);
  assign take  = up_word.valid && !occupied && !up_word.hit && !up_word.stored;

  // occupancy, held entry and the handed-on word; only occupancy and valid flags reset
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied        <= 1'b0;
      down_word.valid <= 1'b0;
    end else if (advance) begin
      if (take) begin
        occupied <= 1'b1;
        entry    <= up_word.value;
      end
      down_word.valid  <= up_word.valid;
      down_word.value  <= up_word.value;
      down_word.hit    <= up_word.hit || match;
      down_word.stored <= up_word.stored || take;
    end
  end

endmodule

// File: sv/first_occurrence_filter.sv
`timescale 1ns / 1ps

// First-occurrence filter: passes on each 32-bit value the first time it
// appears in the stream and drops every later repeat of a recorded value.
// in_ch  (sink):   value_in, valid/ready; one word per accepted handshake.
// out_ch (source): value_out and table_full, valid/ready; a word only for a
//                  value not recorded before.
// Every value walks a row of CAPACITY cells, one cell a cycle unless stalled;
// each cell holds one recorded value and checks the passing word against
// it. The first empty cell a new value reaches records it. A new value that
// finds every cell taken leaves with table_full set and is not recorded.
// Throughput is one word per cycle while the row is not stalled.
// Reset empties all cells and drops words in flight; in_ch.ready is high
// from the first cycle after reset.
// When the receiver stalls, the row keeps moving until a result reaches its
// last cell while out_ch still holds an untaken word; then the whole row
// and in_ch.ready hold until out_ch is taken.
module first_occurrence_filter #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  ffo_in_if.sink    in_ch,
  ffo_out_if.source out_ch
);
  import ffo_pkg::*;

  ffo_word_t             chain [CAPACITY+1];
  logic [CAPACITY-1:0]   occ;
  logic                  advance;
  logic                  emit;

  // head of the row
  always_comb begin
    chain[0].valid  = in_ch.valid;
    chain[0].value  = in_ch.value_in;
    chain[0].hit    = 1'b0;
    chain[0].stored = 1'b0;
  end

  // the row moves unless a result at its end has nowhere to go
  assign emit        = chain[CAPACITY].valid && !chain[CAPACITY].hit;
  assign advance     = !emit || !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ffo_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .up_word  (chain[g]),
      .down_word(chain[g+1]),
      .occupied (occ[g])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance && emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_ch.value_out  <= chain[CAPACITY].value;
      out_ch.table_full <= !chain[CAPACITY].stored;
    end
  end

  // cells fill strictly in order
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    ((occ + CAPACITY'(1)) & occ) == '0)
    else $error("cell occupancy is not contiguous");

  // a full flag only once every cell is taken
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.table_full |-> &occ)
    else $error("table_full reported with a free cell");

  // a repeat is never recorded
  a_hit_not_stored: assert property (@(posedge clk) disable iff (rst)
    chain[CAPACITY].valid |-> !(chain[CAPACITY].hit && chain[CAPACITY].stored))
    else $error("matched word was also recorded");

  // a blocked result at the row end holds the input side
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    emit && out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while the row end is blocked");

endmodule
